// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of the deque.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the clock and disabled while reset is low.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deque assertion failed");

// Concurrent assertion that also holds across reset.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deque assertion failed");

`endif

// ===== hdl/cdq_pkg.sv =====
// Package for the circular deque: sizes, request and status codes, cell control.
package cdq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control broadcast to every cell; ops are already qualified by full/empty.
  typedef struct packed {
    logic              push_front;
    logic              push_rear;
    logic              pop_front;
    logic              pop_rear;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== hdl/cdq_cell.sv =====
// One slot of the deque chain: holds an entry and its occupied bit.
module cdq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cdq_pkg::cell_ctrl_t        ctrl,
  input  logic [cdq_pkg::DATA_W-1:0] prev_data,
  input  logic                       prev_occ,
  input  logic [cdq_pkg::DATA_W-1:0] next_data,
  input  logic                       next_occ,
  output logic [cdq_pkg::DATA_W-1:0] data,
  output logic                       occ,
  output logic                       is_tail
);

  logic [cdq_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                       occ_r, occ_nxt;

  // Entries run from the front cell toward the back; pushes at the front
  // shift the chain back, pops at the front shift it forward.
  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    priority if (ctrl.push_front) begin
      data_nxt = prev_data;
      occ_nxt  = prev_occ;
    end else if (ctrl.push_rear) begin
      // first free cell takes the new rear entry
      if (!occ_r && prev_occ) begin
        data_nxt = ctrl.value;
        occ_nxt  = 1'b1;
      end
    end else if (ctrl.pop_front) begin
      data_nxt = next_data;
      occ_nxt  = next_occ;
    end else if (ctrl.pop_rear) begin
      if (occ_r && !next_occ) begin
        occ_nxt = 1'b0;
      end
    end else begin
      // no operation this cycle: cell holds
      data_nxt = data_r;
      occ_nxt  = occ_r;
    end
  end

  // Occupied bit is control state; data needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign occ     = occ_r;
  assign is_tail = occ_r && !next_occ;

endmodule

// ===== hdl/circular_deque.sv =====
// Top level of the circular deque: chain of slot cells and the result register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid / in_stall | in_req_type, in_push_value
//   out_    | output    | out_valid/out_stall | out_pop_value, out_status,
//           |           |                    | out_now_empty, out_now_full
//
// One request per cycle unless stalled; its result appears in the output
// register next cycle. The chain updates every cell in the cycle of acceptance.
// The rear entry is picked by an AND-OR over the cells' tail flags.
// Reset (rst_n low, synchronous) empties the deque and drops any result.
// in_stall is high only while a held result is stalled at the output.
module circular_deque (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic signed [31:0]         in_push_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_pop_value,
  output logic [1:0]                 out_status,
  output logic                       out_now_empty,
  output logic                       out_now_full
);

  localparam int unsigned D = cdq_pkg::DEPTH;
  localparam int unsigned W = cdq_pkg::DATA_W;

  logic [W-1:0]        cell_data [D];
  logic [D-1:0]        cell_occ;
  logic [D-1:0]        cell_tail;
  cdq_pkg::cell_ctrl_t ctrl;
  cdq_pkg::req_t       req;
  logic                accept;
  logic                is_empty, is_full;
  logic [W-1:0]        rear_data;

  logic                out_valid_r, out_valid_nxt;
  logic [W-1:0]        pop_value_r, pop_value_nxt;
  cdq_pkg::status_t    status_r, status_nxt;
  logic                now_empty_r, now_empty_nxt;
  logic                now_full_r, now_full_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign req      = cdq_pkg::req_t'(in_req_type);
  assign is_empty = !cell_occ[0];
  assign is_full  = cell_occ[D-1];

  // Qualified operations for the chain
  always_comb begin
    ctrl.push_front = accept && (req == cdq_pkg::REQ_PUSH_FRONT) && !is_full;
    ctrl.push_rear  = accept && (req == cdq_pkg::REQ_PUSH_REAR) && !is_full;
    ctrl.pop_front  = accept && (req == cdq_pkg::REQ_POP_FRONT) && !is_empty;
    ctrl.pop_rear   = accept && (req == cdq_pkg::REQ_POP_REAR) && !is_empty;
    ctrl.value      = W'(in_push_value);
  end

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [W-1:0] prev_d, next_d;
    logic         prev_o, next_o;
    if (i == 0) begin : g_front
      assign prev_d = W'(in_push_value);
      assign prev_o = 1'b1;
    end else begin : g_inner_prev
      assign prev_d = cell_data[i-1];
      assign prev_o = cell_occ[i-1];
    end
    if (i == D - 1) begin : g_back
      assign next_d = '0;
      assign next_o = 1'b0;
    end else begin : g_inner_next
      assign next_d = cell_data[i+1];
      assign next_o = cell_occ[i+1];
    end
    cdq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_data (prev_d),
      .prev_occ  (prev_o),
      .next_data (next_d),
      .next_occ  (next_o),
      .data      (cell_data[i]),
      .occ       (cell_occ[i]),
      .is_tail   (cell_tail[i])
    );
  end

  // Rear entry: at most one tail flag is set
  always_comb begin
    rear_data = '0;
    for (int unsigned i = 0; i < D; i++) begin
      rear_data = rear_data | (cell_data[i] & {W{cell_tail[i]}});
    end
  end

  // Result register next state
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    pop_value_nxt = pop_value_r;
    status_nxt    = status_r;
    now_empty_nxt = now_empty_r;
    now_full_nxt  = now_full_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      pop_value_nxt = '0;
      status_nxt    = cdq_pkg::ST_DONE;
      now_empty_nxt = is_empty;
      now_full_nxt  = is_full;
      unique case (req)
        cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR: begin
          if (is_full) begin
            status_nxt = cdq_pkg::ST_OVERFLOW;
          end else begin
            now_empty_nxt = 1'b0;
            now_full_nxt  = cell_occ[D-2];
          end
        end
        cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
          if (is_empty) begin
            status_nxt = cdq_pkg::ST_UNDERFLOW;
          end else begin
            pop_value_nxt = (req == cdq_pkg::REQ_POP_FRONT) ? cell_data[0] : rear_data;
            now_empty_nxt = !cell_occ[1];
            now_full_nxt  = 1'b0;
          end
        end
        default: begin
          status_nxt = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_value_r <= pop_value_nxt;
    status_r    <= status_nxt;
    now_empty_r <= now_empty_nxt;
    now_full_r  <= now_full_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = signed'(pop_value_r);
  assign out_status    = status_r;
  assign out_now_empty = now_empty_r;
  assign out_now_full  = now_full_r;

endmodule

// ===== hdl/cdq_checker.sv =====
// Port-level checker for the circular deque and its bind to the top level.
`include "assert_macros.svh"

module cdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pop_value,
  input logic [1:0]         out_status,
  input logic               out_now_empty,
  input logic               out_now_full
);

  // A stalled result stays offered
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)

  // Reset drops any pending result
  `ASSERT_CLK(a_rst_clears, clk, !rst_n |=> !out_valid)

  // Overflow is reported only on a full deque
  `ASSERT_CLK_RST(a_ovf_full, clk, rst_n, out_valid && (out_status == cdq_pkg::ST_OVERFLOW) |-> out_now_full && !out_now_empty)

  // Underflow leaves the deque empty and returns zero
  `ASSERT_CLK_RST(a_udf_empty, clk, rst_n, out_valid && (out_status == cdq_pkg::ST_UNDERFLOW) |-> out_now_empty && (out_pop_value == 32'sd0))

  // An accepted request yields a result on the next cycle
  `ASSERT_CLK_RST(a_accept_result, clk, rst_n, in_valid && !in_stall |=> out_valid)

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pop_value (out_pop_value),
  .out_status    (out_status),
  .out_now_empty (out_now_empty),
  .out_now_full  (out_now_full)
);
